[design/drc_pkg.sv]
// Shared types, constants and constant functions of the diagonal recurrent cell.
`timescale 1ns / 1ps
`default_nettype none
package drc_pkg;

   localparam int MAX_DIM   = 256;
   localparam int MAX_BATCH = 8;
   localparam int HID_DEPTH = MAX_BATCH * MAX_DIM;
   localparam int HID_AW    = $clog2(HID_DEPTH);
   localparam int COEF_AW   = $clog2(MAX_DIM);

   localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
   localparam logic [1:0] OP_LOAD_HIDDEN = 2'd1;
   localparam logic [1:0] OP_STEP        = 2'd2;

   localparam int EXP_T_STEPS = 16;
   localparam int EXP_S_STEPS = 13;
   localparam int DIV_STEPS   = 13;
   localparam int WB_DEPTH    = 3 + 2 * EXP_T_STEPS + 1 + DIV_STEPS + 1
                                + 2 * EXP_S_STEPS + 1 + DIV_STEPS + 2;

   localparam logic [44:0] FRAC44 = 45'd1 << 44;

   typedef logic [15:0][63:0] exp_tab_type;

   typedef struct packed {
      logic               is_step;
      logic [2:0]         batch;
      logic [7:0]         dim;
      logic signed [15:0] init;
      logic signed [15:0] wx;
      logic signed [15:0] pre;
      logic               neg;
      logic [15:0]        kval;
      logic signed [13:0] hn;
   } side_type;

   typedef struct packed {
      logic [63:0] e;
      logic        any;
   } exp_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [58:0] dsr;
      logic [12:0] quo;
   } div_type;

   function automatic logic [63:0] mul_hi_f(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p00, p01, p10, p11, mid;
      p00 = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      p01 = {32'd0, a[31:0]} * {32'd0, b[63:32]};
      p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
      p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
      mid = {32'd0, p00[63:32]} + {32'd0, p01[31:0]} + {32'd0, p10[31:0]};
      return p11 + {32'd0, p01[63:32]} + {32'd0, p10[63:32]} + {32'd0, mid[63:32]};
   endfunction

   // Entry i holds exp(-2^i / 2048) as a 64-bit fraction.
   function automatic exp_tab_type build_exp_tab_f();
      exp_tab_type tab;
      logic [63:0] acc, term;
      acc  = 64'd0 - (64'd1 << 53);
      term = 64'd1 << 53;
      term = (term >> 11) / 2;  acc = acc + term;
      term = (term >> 11) / 3;  acc = acc - term;
      term = (term >> 11) / 4;  acc = acc + term;
      term = (term >> 11) / 5;  acc = acc - term;
      term = (term >> 11) / 6;  acc = acc + term;
      term = (term >> 11) / 7;  acc = acc - term;
      term = (term >> 11) / 8;  acc = acc + term;
      tab[0] = acc;
      for (int i = 1; i < 16; i++) begin
         tab[i] = mul_hi_f(tab[i-1], tab[i-1]);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab_f();

endpackage
`default_nettype wire

[design/drc_if.sv]
// Request and response channel interfaces of the diagonal recurrent cell.
`timescale 1ns / 1ps
`default_nettype none
interface drc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  batch_index;
   logic [7:0]  dim_index;
   logic [15:0] wx_value;
   logic [15:0] decay_coef;
   logic [15:0] bias_coef;
   logic [15:0] initial_hidden;
   modport source (output valid, opcode, batch_index, dim_index, wx_value, decay_coef,
                   bias_coef, initial_hidden, input ready);
   modport sink (input valid, opcode, batch_index, dim_index, wx_value, decay_coef,
                 bias_coef, initial_hidden, output ready);
endinterface

interface drc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  out_batch;
   logic [7:0]  out_dim;
   logic [13:0] new_hidden;
   logic [12:0] gated_out;
   logic [15:0] pre_activation;
   modport source (output valid, out_batch, out_dim, new_hidden, gated_out, pre_activation,
                   input ready);
   modport sink (input valid, out_batch, out_dim, new_hidden, gated_out, pre_activation,
                 output ready);
endinterface
`default_nettype wire

[design/diagonal_recurrent_cell_forward.sv]
// Top level of the diagonal recurrent cell forward step.
//
// The cell takes one word per clock unless stalled, held off or clearing, and returns one
// result word per step word; coefficient and hidden-value loads return nothing. The depth
// is set by the two exponential product chains (one 64-bit multiply over two stages per
// factor) and the two 13-bit restoring dividers for tanh and sigmoid. A word that names
// the same (batch, dimension) element as a hidden-value load or step still in the pipeline
// is held off until that word has written the hidden store. After reset no word is taken
// until all 2048 hidden entries are cleared. A stalled result holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module diagonal_recurrent_cell_forward (
   input  logic clock,
   input  logic reset,
   drc_req_if.sink   req_chan,
   drc_rsp_if.source rsp_chan
);
   import drc_pkg::*;

   function automatic div_type div_init_f(input logic [44:0] e44, input logic [44:0] p);
      div_type     d;
      logic [45:0] den;
      den   = {1'b0, FRAC44} + {1'b0, e44};
      d.rem = {3'd0, p, 13'd0} + {15'd0, den};
      d.dsr = {den, 13'd0};
      d.quo = '0;
      return d;
   endfunction

   logic                adv, accept, writes, hit;
   logic [HID_AW-1:0]   req_addr;
   logic                haz_v_ff [WB_DEPTH];
   logic [HID_AW-1:0]   haz_addr_ff [WB_DEPTH];
   logic                clear_ff, clear_in;
   logic [HID_AW-1:0]   clear_cnt_ff, clear_cnt_in;

   logic                hid_we;
   logic [HID_AW-1:0]   hid_waddr;
   logic [15:0]         hid_wdata, hid_rdata;
   logic [31:0]         coef_rdata;

   side_type            s1_ff, s1_in, s2_ff, s3_ff, s3_in, s36_ff, s50_ff, s50_in;
   side_type            s77_ff, s91_ff, s92_ff, s93_ff;
   logic signed [31:0]  mul_ff, mul_in;
   logic signed [15:0]  bias2_ff;
   logic signed [32:0]  rnd_sum;
   logic signed [20:0]  rnd;
   logic signed [21:0]  tot;
   logic signed [15:0]  v;

   side_type            side_t [EXP_T_STEPS+1];
   exp_type             exp_t  [EXP_T_STEPS+1];
   side_type            side_s [EXP_S_STEPS+1];
   exp_type             exp_s  [EXP_S_STEPS+1];
   side_type            side_dt [DIV_STEPS+1];
   div_type             div_t  [DIV_STEPS+1];
   side_type            side_ds [DIV_STEPS+1];
   div_type             div_s  [DIV_STEPS+1];
   div_type             d36_ff, d36_in, d77_ff, d77_in;
   logic [44:0]         e44_t, e44_s;

   logic signed [27:0]  sq;
   logic [24:0]         hh_ff;
   logic [12:0]         sg91_ff;
   logic [37:0]         prod_ff;
   logic [38:0]         gsum;
   logic [12:0]         gated_ff;
   logic                out_v_ff, out_v_in;

   assign adv      = !(out_v_ff && !rsp_chan.ready);
   assign req_addr = {req_chan.batch_index, req_chan.dim_index};
   assign writes   = (req_chan.opcode == OP_LOAD_HIDDEN) || (req_chan.opcode == OP_STEP);
   assign accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < WB_DEPTH; j++) begin
         hit = hit | (haz_v_ff[j] && (haz_addr_ff[j] == req_addr));
      end
   end

   assign req_chan.ready = adv && !clear_ff && !hit;

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == HID_AW'(HID_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clear_ff) begin
         hid_we    = 1'b1;
         hid_waddr = clear_cnt_ff;
         hid_wdata = '0;
      end else begin
         hid_we    = adv && haz_v_ff[WB_DEPTH-1];
         hid_waddr = {s92_ff.batch, s92_ff.dim};
         hid_wdata = s92_ff.is_step ? {{2{s92_ff.hn[13]}}, s92_ff.hn} : s92_ff.init;
      end
   end

   drc_ram #(.WIDTH(16), .DEPTH(HID_DEPTH)) u_hid_ram (
      .clock (clock),
      .we    (hid_we),
      .waddr (hid_waddr),
      .wdata (hid_wdata),
      .re    (adv),
      .raddr (req_addr),
      .rdata (hid_rdata)
   );

   drc_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_coef_ram (
      .clock (clock),
      .we    (accept && (req_chan.opcode == OP_LOAD_COEF)),
      .waddr (req_chan.dim_index),
      .wdata ({req_chan.decay_coef, req_chan.bias_coef}),
      .re    (adv),
      .raddr (req_chan.dim_index),
      .rdata (coef_rdata)
   );

   always_comb begin
      s1_in         = '0;
      s1_in.is_step = (req_chan.opcode == OP_STEP);
      s1_in.batch   = req_chan.batch_index;
      s1_in.dim     = req_chan.dim_index;
      s1_in.init    = req_chan.initial_hidden;
      s1_in.wx      = req_chan.wx_value;
      mul_in        = $signed(coef_rdata[31:16]) * $signed(hid_rdata);
   end

   always_comb begin
      rnd_sum = {mul_ff[31], mul_ff} + 33'sd2048;
      rnd     = rnd_sum[32:12];
      tot     = {{6{s2_ff.wx[15]}}, s2_ff.wx} + {rnd[20], rnd}
                + {{6{bias2_ff[15]}}, bias2_ff};
      if (tot > 22'sd32767) begin
         v = 16'sh7FFF;
      end else if (tot < -22'sd32768) begin
         v = -16'sh8000;
      end else begin
         v = tot[15:0];
      end
      s3_in      = s2_ff;
      s3_in.pre  = v;
      s3_in.neg  = v[15];
      s3_in.kval = v[15] ? (16'd0 - v) : v;
   end

   assign side_t[0] = s3_ff;
   assign exp_t[0]  = '0;

   for (genvar i = 0; i < EXP_T_STEPS; i++) begin : g_exp_t
      drc_exp_step u_step (
         .clock    (clock),
         .enable   (adv),
         .take     (side_t[i].kval[i]),
         .factor   (EXP_TAB[i]),
         .side_in  (side_t[i]),
         .exp_in   (exp_t[i]),
         .side_out (side_t[i+1]),
         .exp_out  (exp_t[i+1])
      );
   end

   assign e44_t  = exp_t[EXP_T_STEPS].any ? {1'b0, exp_t[EXP_T_STEPS].e[63:20]} : FRAC44;
   assign d36_in = div_init_f(e44_t, FRAC44 - e44_t);

   assign side_dt[0] = s36_ff;
   assign div_t[0]   = d36_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div_t
      drc_div_step u_step (
         .clock    (clock),
         .enable   (adv),
         .side_in  (side_dt[i]),
         .div_in   (div_t[i]),
         .side_out (side_dt[i+1]),
         .div_out  (div_t[i+1])
      );
   end

   always_comb begin
      s50_in      = side_dt[DIV_STEPS];
      s50_in.hn   = s50_in.neg ? (14'sd0 - $signed({1'b0, div_t[DIV_STEPS].quo}))
                               : $signed({1'b0, div_t[DIV_STEPS].quo});
      s50_in.kval = {2'd0, div_t[DIV_STEPS].quo, 1'b0};
   end

   assign side_s[0] = s50_ff;
   assign exp_s[0]  = '0;

   for (genvar i = 0; i < EXP_S_STEPS; i++) begin : g_exp_s
      drc_exp_step u_step (
         .clock    (clock),
         .enable   (adv),
         .take     (side_s[i].kval[i+1]),
         .factor   (EXP_TAB[i+1]),
         .side_in  (side_s[i]),
         .exp_in   (exp_s[i]),
         .side_out (side_s[i+1]),
         .exp_out  (exp_s[i+1])
      );
   end

   assign e44_s  = exp_s[EXP_S_STEPS].any ? {1'b0, exp_s[EXP_S_STEPS].e[63:20]} : FRAC44;
   assign d77_in = div_init_f(e44_s, side_s[EXP_S_STEPS].neg ? e44_s : FRAC44);

   assign side_ds[0] = s77_ff;
   assign div_s[0]   = d77_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div_s
      drc_div_step u_step (
         .clock    (clock),
         .enable   (adv),
         .side_in  (side_ds[i]),
         .div_in   (div_s[i]),
         .side_out (side_ds[i+1]),
         .div_out  (div_s[i+1])
      );
   end

   assign sq       = side_ds[DIV_STEPS].hn * side_ds[DIV_STEPS].hn;
   assign gsum     = {1'b0, prod_ff} + (39'd1 << 23);
   assign out_v_in = haz_v_ff[WB_DEPTH-1] && s92_ff.is_step;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s1_ff;
         mul_ff   <= mul_in;
         bias2_ff <= $signed(coef_rdata[15:0]);
         s3_ff    <= s3_in;
         s36_ff   <= side_t[EXP_T_STEPS];
         d36_ff   <= d36_in;
         s50_ff   <= s50_in;
         s77_ff   <= side_s[EXP_S_STEPS];
         d77_ff   <= d77_in;
         s91_ff   <= side_ds[DIV_STEPS];
         hh_ff    <= sq[24:0];
         sg91_ff  <= div_s[DIV_STEPS].quo;
         s92_ff   <= s91_ff;
         prod_ff  <= {13'd0, hh_ff} * {25'd0, sg91_ff};
         s93_ff   <= s92_ff;
         gated_ff <= gsum[36:24];
      end
      if (adv) begin
         haz_addr_ff[0] <= req_addr;
         for (int j = 1; j < WB_DEPTH; j++) begin
            haz_addr_ff[j] <= haz_addr_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         out_v_ff     <= 1'b0;
         for (int j = 0; j < WB_DEPTH; j++) begin
            haz_v_ff[j] <= 1'b0;
         end
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         if (adv) begin
            out_v_ff    <= out_v_in;
            haz_v_ff[0] <= accept && writes;
            for (int j = 1; j < WB_DEPTH; j++) begin
               haz_v_ff[j] <= haz_v_ff[j-1];
            end
         end
      end
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.out_batch      = s93_ff.batch;
   assign rsp_chan.out_dim        = s93_ff.dim;
   assign rsp_chan.new_hidden     = s93_ff.hn;
   assign rsp_chan.gated_out      = gated_ff;
   assign rsp_chan.pre_activation = s93_ff.pre;

   a_no_read_write_collision: assert property (@(posedge clock) disable iff (reset)
      !(hid_we && accept && (req_addr == hid_waddr)))
      else $error("Hidden store written at the address of a word being taken.");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_chan.ready)
      else $error("Word taken while the hidden store is being cleared.");

   a_hidden_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ($signed(rsp_chan.new_hidden) <= 14'sd4096
                          && $signed(rsp_chan.new_hidden) >= -14'sd4096
                          && rsp_chan.gated_out <= 13'd4096))
      else $error("Result word out of the activation range.");

endmodule
`default_nettype wire

[design/drc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module drc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[design/drc_exp_step.sv]
// One factor of the exponential product: a two-stage 64-bit fractional multiply.
`timescale 1ns / 1ps
`default_nettype none
module drc_exp_step (
   input  logic              clock,
   input  logic              enable,
   input  logic              take,
   input  logic [63:0]       factor,
   input  drc_pkg::side_type side_in,
   input  drc_pkg::exp_type  exp_in,
   output drc_pkg::side_type side_out,
   output drc_pkg::exp_type  exp_out
);
   import drc_pkg::*;

   side_type    side_a_ff, side_b_ff;
   exp_type     exp_a_ff, exp_b_ff, exp_b_in;
   logic        take_a_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0] p00_in, p01_in, p10_in, p11_in;
   logic [33:0] mid;
   logic [63:0] hi;

   always_comb begin
      p00_in = {32'd0, exp_in.e[31:0]} * {32'd0, factor[31:0]};
      p01_in = {32'd0, exp_in.e[31:0]} * {32'd0, factor[63:32]};
      p10_in = {32'd0, exp_in.e[63:32]} * {32'd0, factor[31:0]};
      p11_in = {32'd0, exp_in.e[63:32]} * {32'd0, factor[63:32]};
   end

   always_comb begin
      mid = {2'd0, p00_ff[63:32]} + {2'd0, p01_ff[31:0]} + {2'd0, p10_ff[31:0]};
      hi  = p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]} + {62'd0, mid[33:32]};
      exp_b_in.any = exp_a_ff.any | take_a_ff;
      if (take_a_ff) begin
         exp_b_in.e = exp_a_ff.any ? hi : factor;
      end else begin
         exp_b_in.e = exp_a_ff.e;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_a_ff <= side_in;
         exp_a_ff  <= exp_in;
         take_a_ff <= take;
         p00_ff    <= p00_in;
         p01_ff    <= p01_in;
         p10_ff    <= p10_in;
         p11_ff    <= p11_in;
         side_b_ff <= side_a_ff;
         exp_b_ff  <= exp_b_in;
      end
   end

   assign side_out = side_b_ff;
   assign exp_out  = exp_b_ff;
endmodule
`default_nettype wire

[design/drc_div_step.sv]
// One quotient bit of a restoring division.
`timescale 1ns / 1ps
`default_nettype none
module drc_div_step (
   input  logic              clock,
   input  logic              enable,
   input  drc_pkg::side_type side_in,
   input  drc_pkg::div_type  div_in,
   output drc_pkg::side_type side_out,
   output drc_pkg::div_type  div_out
);
   import drc_pkg::*;

   side_type    side_ff;
   div_type     div_ff, div_in_next;
   logic        fits;
   logic [60:0] diff;

   always_comb begin
      fits = div_in.rem >= {2'd0, div_in.dsr};
      diff = fits ? (div_in.rem - {2'd0, div_in.dsr}) : div_in.rem;
      div_in_next.rem = {diff[59:0], 1'b0};
      div_in_next.dsr = div_in.dsr;
      div_in_next.quo = {div_in.quo[11:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff <= side_in;
         div_ff  <= div_in_next;
      end
   end

   assign side_out = side_ff;
   assign div_out  = div_ff;
endmodule
`default_nettype wire

[test/diagonal_recurrent_cell_forward_tb.sv]
// Self-checking testbench of the diagonal recurrent cell forward step with random idling.
`timescale 1ns / 1ps
`default_nettype none
module diagonal_recurrent_cell_forward_tb;
   import drc_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 150;
   localparam int RANDOM_WORDS = 1700;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  batch;
      logic [7:0]  dim;
      logic [15:0] wx;
      logic [15:0] decay;
      logic [15:0] bias;
      logic [15:0] init;
   } cell_word_type;

   typedef struct packed {
      logic [2:0]  batch;
      logic [7:0]  dim;
      logic [13:0] hidden;
      logic [12:0] gated;
      logic [15:0] pre;
   } step_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   drc_req_if req_chan();
   drc_rsp_if rsp_chan();

   diagonal_recurrent_cell_forward dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   cell_word_type pending_words[$];
   step_result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   logic stimulus_done = 1'b0;

   logic signed [15:0] model_hidden [HID_DEPTH];
   logic signed [15:0] model_decay [MAX_DIM];
   logic signed [15:0] model_bias [MAX_DIM];
   logic [63:0] decay_powers [16];
   bit coef_loaded [MAX_DIM];

   function automatic logic [63:0] frac_mul_high(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[127:64];
   endfunction

   function automatic logic [63:0] exp_neg_q44(input logic [31:0] k);
      logic [63:0] e;
      bit seen;
      e = 64'd0;
      seen = 0;
      if (k == 0) return 64'd1 << 44;
      for (int i = 0; i < 16; i++) begin
         if (k[i]) begin
            e = seen ? frac_mul_high(e, decay_powers[i]) : decay_powers[i];
            seen = 1;
         end
      end
      return e >> 20;
   endfunction

   function automatic logic [63:0] round_ratio_q12(input logic [63:0] p, input logic [63:0] den);
      return (64'd8192 * p + den) / (64'd2 * den);
   endfunction

   function automatic int tanh_q12(input int v);
      logic [63:0] e;
      int r;
      e = exp_neg_q44(v < 0 ? -v : v);
      r = int'(round_ratio_q12((64'd1 << 44) - e, (64'd1 << 44) + e));
      return v < 0 ? -r : r;
   endfunction

   function automatic int sigmoid_q12(input int h);
      logic [63:0] e;
      e = exp_neg_q44(2 * (h < 0 ? -h : h));
      return int'(round_ratio_q12(h < 0 ? e : (64'd1 << 44), (64'd1 << 44) + e));
   endfunction

   task automatic apply_word(input cell_word_type w);
      int addr;
      longint prod, sum;
      int hn, s;
      logic [63:0] hh, g;
      step_result_type r;
      addr = int'(w.batch) * MAX_DIM + int'(w.dim);
      case (w.opcode)
         OP_LOAD_COEF: begin
            model_decay[w.dim] = w.decay;
            model_bias[w.dim] = w.bias;
         end
         OP_LOAD_HIDDEN: model_hidden[addr] = w.init;
         OP_STEP: begin
            prod = longint'(model_decay[w.dim]) * longint'(model_hidden[addr]);
            prod = (prod + 2048) >>> 12;
            sum = longint'($signed(w.wx)) + prod + longint'(model_bias[w.dim]);
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            hn = tanh_q12(int'(sum));
            model_hidden[addr] = 16'(hn);
            s = sigmoid_q12(hn);
            hh = 64'(longint'(hn) * longint'(hn));
            g = (hh * 64'(s) + (64'd1 << 23)) >> 24;
            r.batch = w.batch;
            r.dim = w.dim;
            r.hidden = 14'(hn);
            r.gated = g[12:0];
            r.pre = 16'(sum);
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: the word in front of the queue is offered until it is taken.
   int req_gap = 0;
   bit req_quiet = 0;
   always @(posedge clock) begin
      cell_word_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            w = pending_words.pop_front();
            apply_word(w);
            if (!req_quiet) req_gap = idle_length();
         end
         if ($urandom_range(0, 199) == 0) req_quiet = ~req_quiet;
         if (req_chan.valid && !req_chan.ready) begin
            req_chan.valid <= 1'b1;
         end else if (req_gap > 0 || pending_words.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_chan.valid <= 1'b0;
         end else begin
            w = pending_words[0];
            req_chan.valid <= 1'b1;
            req_chan.opcode <= w.opcode;
            req_chan.batch_index <= w.batch;
            req_chan.dim_index <= w.dim;
            req_chan.wx_value <= w.wx;
            req_chan.decay_coef <= w.decay;
            req_chan.bias_coef <= w.bias;
            req_chan.initial_hidden <= w.init;
         end
      end
   end

   // Monitor: compares each result word with the oldest prediction.
   int rsp_gap = 0;
   bit rsp_quiet = 0;
   always @(posedge clock) begin
      step_result_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("FAILURE");
         $finish;
      end else if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result batch %0d dim %0d", $time,
                        rsp_chan.out_batch, rsp_chan.out_dim);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_chan.out_batch !== e.batch || rsp_chan.out_dim !== e.dim ||
                   rsp_chan.new_hidden !== e.hidden || rsp_chan.gated_out !== e.gated ||
                   rsp_chan.pre_activation !== e.pre) begin
                  $display("%0t: expected b%0d d%0d h%h g%h v%h, got b%0d d%0d h%h g%h v%h",
                           $time, e.batch, e.dim, e.hidden, e.gated, e.pre,
                           rsp_chan.out_batch, rsp_chan.out_dim, rsp_chan.new_hidden,
                           rsp_chan.gated_out, rsp_chan.pre_activation);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_quiet = ~rsp_quiet;
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (!rsp_quiet) rsp_gap = idle_length();
            rsp_chan.ready <= (rsp_gap == 0);
         end
      end
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 12287)) - 6144);
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] op, input logic [2:0] b, input logic [7:0] d,
                             input logic [15:0] wx, input logic [15:0] dc,
                             input logic [15:0] bc, input logic [15:0] hi);
      cell_word_type w;
      w = '{op, b, d, wx, dc, bc, hi};
      if (op == OP_LOAD_COEF) coef_loaded[d] = 1;
      pending_words.push_back(w);
   endtask

   initial begin
      logic [63:0] acc, term;
      int r;
      logic [2:0] b;
      logic [7:0] d;
      logic [7:0] hot_dims [4];
      acc = 64'd0 - (64'd1 << 53);
      term = 64'd1 << 53;
      for (int n = 2; n <= 8; n++) begin
         term = (term >> 11) / n;
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      decay_powers[0] = acc;
      for (int i = 1; i < 16; i++) begin
         decay_powers[i] = frac_mul_high(decay_powers[i-1], decay_powers[i-1]);
      end
      for (int i = 0; i < HID_DEPTH; i++) model_hidden[i] = '0;
      for (int i = 0; i < MAX_DIM; i++) begin
         model_decay[i] = '0;
         model_bias[i] = '0;
         coef_loaded[i] = 0;
      end
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.batch_index = '0;
      req_chan.dim_index = '0;
      req_chan.wx_value = '0;
      req_chan.decay_coef = '0;
      req_chan.bias_coef = '0;
      req_chan.initial_hidden = '0;
      rsp_chan.ready = 1'b0;

      queue_word(OP_LOAD_COEF, 3'd0, 8'd0, 16'h1234, 16'h7fff, 16'h8000, 16'hffff);
      queue_word(OP_LOAD_COEF, 3'd7, 8'd255, 16'hedcb, 16'h8000, 16'h7fff, 16'h0000);
      queue_word(OP_LOAD_COEF, 3'd2, 8'd17, 16'h0000, 16'h0000, 16'h0000, 16'h5555);
      queue_word(OP_LOAD_HIDDEN, 3'd0, 8'd0, 16'hffff, 16'h0000, 16'hffff, 16'h7fff);
      queue_word(OP_STEP, 3'd0, 8'd0, 16'h7fff, 16'hffff, 16'h0000, 16'haaaa);
      queue_word(OP_STEP, 3'd0, 8'd0, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
      queue_word(OP_LOAD_HIDDEN, 3'd7, 8'd255, 16'h0000, 16'hffff, 16'h0000, 16'h8000);
      queue_word(OP_STEP, 3'd7, 8'd255, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_STEP, 3'd7, 8'd255, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_STEP, 3'd3, 8'd17, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_UNUSED, 3'd3, 8'd17, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      queue_word(OP_STEP, 3'd3, 8'd17, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_LOAD_COEF, 3'd5, 8'd17, 16'h0000, 16'h1000, 16'hf000, 16'h0000);
      queue_word(OP_STEP, 3'd3, 8'd17, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_LOAD_HIDDEN, 3'd2, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_STEP, 3'd2, 8'd0, 16'h0800, 16'h0000, 16'h0000, 16'h0000);
      queue_word(OP_STEP, 3'd1, 8'd255, 16'hf800, 16'h0000, 16'h0000, 16'h0000);

      // A few hot dimensions keep recurrence chains and back-to-back address repeats common.
      for (int i = 0; i < 4; i++) hot_dims[i] = 8'($urandom);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         r = $urandom_range(0, 99);
         b = 3'($urandom);
         d = ($urandom_range(0, 1) == 0) ? hot_dims[$urandom_range(0, 3)] : 8'($urandom);
         if (r < 4) begin
            queue_word(OP_UNUSED, b, d, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
         end else if (r < 20 || !coef_loaded[d]) begin
            queue_word(OP_LOAD_COEF, b, d, 16'($urandom), pick_value(), pick_value(),
                       16'($urandom));
         end else if (r < 32) begin
            queue_word(OP_LOAD_HIDDEN, b, d, 16'($urandom), 16'($urandom), 16'($urandom),
                       pick_value());
         end else begin
            if ($urandom_range(0, 2) == 0) b = 3'($urandom_range(0, 1));
            queue_word(OP_STEP, b, d, pick_value(), 16'($urandom), 16'($urandom),
                       16'($urandom));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0t: %0d errors, %0d results missing", $time, errors,
                  expected_results.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
